// ===== hw/rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types, codes and sizes shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BLOCKS     = 256;
  localparam int MAX_WAITERS    = 255;
  localparam int MIN_BLOCK_SIZE = 8;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int WAIT_W = 8;
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 32;
  localparam int PROD_W = IDX_W + SIZE_W;

  localparam logic [CNT_W-1:0]  FREE_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(MAX_WAITERS);
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(MIN_BLOCK_SIZE);

  typedef enum logic [1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_BLOCK_SIZE   = 2'd1,
    REG_BLOCK_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_INIT       = 3'd0,
    MODE_ALLOC      = 3'd1,
    MODE_ALLOC_WAIT = 3'd2,
    MODE_FREE       = 3'd3,
    MODE_DESTROY    = 3'd4,
    MODE_INFO       = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNAVAIL = 3'd1,
    ST_QUEUED  = 3'd2,
    ST_HANDED  = 3'd3,
    ST_REJECT  = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_INIT,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic init_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_go;
    logic init_last;
    logic out_busy;
  } dp_status_t;

  // status sits in the lowest bits
  typedef struct packed {
    logic [SIZE_W-1:0] size_of_block;
    logic [CNT_W-1:0]  total_blocks;
    logic [WAIT_W-1:0] removed_waiters;
    logic [WAIT_W-1:0] waiting_count;
    logic [CNT_W-1:0]  free_blocks;
    logic [ADDR_W-1:0] granted_address;
    logic [IDX_W-1:0]  granted_index;
    status_t           status;
  } result_t;

  localparam int RES_W   = $bits(result_t);
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== hw/rtl/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: accept, execute, init fill walk, result hand-off.
// ----------------------------------------------------------------------------
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      CS_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.init_go ? CS_INIT : CS_DONE;
      end
      CS_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_next = CS_DONE;
        end
      end
      CS_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/fbpa_dp.sv =====
// ----------------------------------------------------------------------------
// fbpa_dp
// Pool datapath: config and pool registers, free ring pointers and counts,
// address multiply-add, output register.
// ----------------------------------------------------------------------------
module fbpa_dp
  import fbpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic [2:0]        in_mode,
  input  logic [IDX_W-1:0]  in_index,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output result_t           m_data
);

  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] cfg_size;
  logic [CNT_W-1:0]  cfg_count;

  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] pool_size;
  logic [CNT_W-1:0]  pool_count;
  logic [IDX_W-1:0]  head_ptr;
  logic [IDX_W-1:0]  tail_ptr;
  logic [CNT_W-1:0]  free_total;
  logic [WAIT_W-1:0] waiter_total;
  logic [CNT_W-1:0]  init_cnt;

  mode_t             req_mode;
  logic [IDX_W-1:0]  req_idx;
  status_t           res_status;
  logic              res_grant;
  logic [IDX_W-1:0]  res_gidx;
  logic [WAIT_W-1:0] res_removed;
  logic [CNT_W-1:0]  res_tot;
  logic [SIZE_W-1:0] res_sz;
  logic [PROD_W-1:0] product;

  status_t           res_status_next;
  logic              res_grant_next;
  logic [IDX_W-1:0]  res_gidx_next;
  logic [WAIT_W-1:0] res_removed_next;
  logic [CNT_W-1:0]  res_tot_next;
  logic [SIZE_W-1:0] res_sz_next;

  logic              size_ok;
  logic [CNT_W-1:0]  n_clip;
  logic [IDX_W-1:0]  ring_rd;
  logic              ring_we;
  logic [IDX_W-1:0]  ring_waddr;
  logic [IDX_W-1:0]  ring_wdata;
  logic              free_push;
  logic [IDX_W-1:0]  exec_gidx;

  assign size_ok = (cfg_size >= SIZE_MIN);
  assign n_clip  = (cfg_count > FREE_MAX) ? FREE_MAX : cfg_count;

  assign free_push = cmd.exec && (req_mode == MODE_FREE) && (waiter_total == '0)
                     && (free_total != FREE_MAX);

  assign ring_we    = cmd.init_step || free_push;
  assign ring_waddr = cmd.init_step ? init_cnt[IDX_W-1:0] : tail_ptr;
  assign ring_wdata = cmd.init_step ? init_cnt[IDX_W-1:0] : req_idx;
  assign exec_gidx  = (req_mode == MODE_FREE) ? req_idx : ring_rd;

  assign sts.init_go   = (req_mode == MODE_INIT) && size_ok && (n_clip != '0);
  assign sts.init_last = (CNT_W'(init_cnt + 1'b1) == pool_count);
  assign sts.out_busy  = m_tvalid && !m_tready;

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (head_ptr),
    .rd_data (ring_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      cfg_size     <= SIZE_W'(64);
      cfg_count    <= '0;
      pool_base    <= '0;
      pool_size    <= SIZE_W'(64);
      pool_count   <= '0;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      free_total   <= '0;
      waiter_total <= '0;
      init_cnt     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_ADDRESS: base_address <= cfg_data;
          REG_BLOCK_SIZE:   cfg_size     <= cfg_data[SIZE_W-1:0];
          REG_BLOCK_COUNT:  cfg_count    <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (cmd.exec) begin
        case (req_mode) inside
          MODE_INIT: begin
            if (size_ok) begin
              pool_base    <= base_address;
              pool_size    <= cfg_size;
              pool_count   <= n_clip;
              head_ptr     <= '0;
              tail_ptr     <= n_clip[IDX_W-1:0];
              free_total   <= n_clip;
              waiter_total <= '0;
              init_cnt     <= '0;
            end
          end
          MODE_ALLOC, MODE_ALLOC_WAIT: begin
            if (free_total != '0) begin
              head_ptr   <= head_ptr + 1'b1;
              free_total <= free_total - 1'b1;
            end else if (req_mode == MODE_ALLOC_WAIT && waiter_total != WAIT_MAX) begin
              waiter_total <= waiter_total + 1'b1;
            end
          end
          MODE_FREE: begin
            if (waiter_total != '0) begin
              waiter_total <= waiter_total - 1'b1;
            end else if (free_push) begin
              tail_ptr   <= tail_ptr + 1'b1;
              free_total <= free_total + 1'b1;
            end
          end
          MODE_DESTROY: waiter_total <= '0;
          default: ;
        endcase
      end

      if (cmd.init_step) begin
        init_cnt <= init_cnt + 1'b1;
      end

      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // reply fields for the request in execution
  always_comb begin
    res_status_next  = ST_OK;
    res_grant_next   = 1'b0;
    res_gidx_next    = '0;
    res_removed_next = '0;
    res_tot_next     = '0;
    res_sz_next      = '0;
    case (req_mode) inside
      MODE_INIT: begin
        if (!size_ok) begin
          res_status_next = ST_REJECT;
        end
      end
      MODE_ALLOC, MODE_ALLOC_WAIT: begin
        if (free_total != '0) begin
          res_grant_next = 1'b1;
          res_gidx_next  = ring_rd;
        end else if (req_mode == MODE_ALLOC_WAIT && waiter_total != WAIT_MAX) begin
          res_status_next = ST_QUEUED;
        end else begin
          res_status_next = ST_UNAVAIL;
        end
      end
      MODE_FREE: begin
        if (waiter_total != '0) begin
          res_status_next = ST_HANDED;
          res_grant_next  = 1'b1;
          res_gidx_next   = req_idx;
        end else if (free_total == FREE_MAX) begin
          res_status_next = ST_FULL;
        end
      end
      MODE_DESTROY: res_removed_next = waiter_total;
      MODE_INFO: begin
        res_tot_next = pool_count;
        res_sz_next  = pool_size;
      end
      default: res_status_next = ST_UNAVAIL;
    endcase
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode <= mode_t'(in_mode);
      req_idx  <= in_index;
    end

    if (cmd.exec) begin
      product     <= PROD_W'(exec_gidx) * PROD_W'(pool_size);
      res_status  <= res_status_next;
      res_grant   <= res_grant_next;
      res_gidx    <= res_gidx_next;
      res_removed <= res_removed_next;
      res_tot     <= res_tot_next;
      res_sz      <= res_sz_next;
    end

    if (cmd.load_out) begin
      m_data.status          <= res_status;
      m_data.granted_index   <= res_gidx;
      m_data.granted_address <= res_grant ? pool_base + ADDR_W'(product) : '0;
      m_data.free_blocks     <= free_total;
      m_data.waiting_count   <= waiter_total;
      m_data.removed_waiters <= res_removed;
      m_data.total_blocks    <= res_tot;
      m_data.size_of_block   <= res_sz;
    end
  end

endmodule

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal-size blocks with a FIFO ring of free block indices.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tdata: mode[2:0], block_index[10:3]
//   m_*      out  tvalid/tready      tdata: result fields, see m_tdata
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// A request runs through accept with ring read, ring update and index
// multiply, then address add into the output register.
// Init adds a fill walk with one ring write per block (one write port).
// rst is synchronous; ring contents are undefined until init writes them.
// A finished result waits in the output register; the next request is
// accepted meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  // mode[2:0], block_index[10:3], zero pad
  input  logic [15:0]        s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // status[2:0], granted_index[10:3], granted_address[42:11],
  // free_blocks[51:43], waiting_count[59:52], removed_waiters[67:60],
  // total_blocks[76:68], size_of_block[92:77], zero pad
  output logic [TDATA_W-1:0] m_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  result_t    res;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (s_tdata[2:0]),
    .in_index  (s_tdata[10:3]),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_data    (res)
  );

  assign m_tdata = TDATA_W'(res);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(m_tvalid && !m_tready))
    else $error("output register overwritten while stalled");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.free_blocks <= FREE_MAX))
    else $error("free count beyond pool capacity");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.exec, cmd.init_step, cmd.load_out}))
    else $error("sequencer issued overlapping commands");

endmodule

// ===== test/fbpa_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_result_checker
// Watches the config port and both stream channels of the block pool
// allocator, keeps its own copy of the pool state, predicts one reply per
// accepted request and compares every reply field with that prediction.
// ----------------------------------------------------------------------------
module fbpa_result_checker
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  // mode[2:0], block_index[10:3], zero pad
  input  logic [15:0]        s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  // status[2:0], granted_index[10:3], granted_address[42:11],
  // free_blocks[51:43], waiting_count[59:52], removed_waiters[67:60],
  // total_blocks[76:68], size_of_block[92:77], zero pad
  input  logic [TDATA_W-1:0] m_tdata,
  output int                 fail_count,
  output int                 pending
);

  logic [ADDR_W-1:0] reg_base;
  logic [SIZE_W-1:0] reg_size;
  logic [CNT_W-1:0]  reg_count;

  logic [IDX_W-1:0]  idx_ring [MAX_BLOCKS];
  logic [IDX_W-1:0]  rd_ptr;
  logic [IDX_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  n_free;
  logic [WAIT_W-1:0] n_wait;
  logic [ADDR_W-1:0] act_base;
  logic [SIZE_W-1:0] act_size;
  logic [CNT_W-1:0]  act_count;

  result_t expected_replies [$];
  result_t want;
  result_t got;
  int      mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [ADDR_W-1:0] block_addr(input logic [IDX_W-1:0] idx);
    return act_base + {24'd0, idx} * {16'd0, act_size};
  endfunction

  // advance the pool copy by one request and return the reply it gives
  function automatic result_t pool_step(input logic [2:0] mode,
                                        input logic [IDX_W-1:0] idx);
    result_t          r;
    logic [CNT_W-1:0] n;
    r = '0;
    r.status = ST_OK;
    case (mode) inside
      MODE_INIT: begin
        if (reg_size < SIZE_MIN) begin
          r.status = ST_REJECT;
        end else begin
          n = (reg_count > FREE_MAX) ? FREE_MAX : reg_count;
          act_base  = reg_base;
          act_size  = reg_size;
          act_count = n;
          for (int i = 0; i < int'(n); i++) idx_ring[i] = i[IDX_W-1:0];
          rd_ptr = '0;
          wr_ptr = n[IDX_W-1:0];
          n_free = n;
          n_wait = '0;
        end
      end
      MODE_ALLOC, MODE_ALLOC_WAIT: begin
        if (n_free > 0) begin
          r.granted_index   = idx_ring[rd_ptr];
          r.granted_address = block_addr(idx_ring[rd_ptr]);
          rd_ptr = rd_ptr + 1'b1;
          n_free = n_free - 1'b1;
        end else if (mode == MODE_ALLOC_WAIT && n_wait < WAIT_MAX) begin
          n_wait = n_wait + 1'b1;
          r.status = ST_QUEUED;
        end else begin
          r.status = ST_UNAVAIL;
        end
      end
      MODE_FREE: begin
        if (n_wait > 0) begin
          n_wait = n_wait - 1'b1;
          r.status          = ST_HANDED;
          r.granted_index   = idx;
          r.granted_address = block_addr(idx);
        end else if (n_free >= FREE_MAX) begin
          r.status = ST_FULL;
        end else begin
          idx_ring[wr_ptr] = idx;
          wr_ptr = wr_ptr + 1'b1;
          n_free = n_free + 1'b1;
        end
      end
      MODE_DESTROY: begin
        r.removed_waiters = n_wait;
        n_wait = '0;
      end
      MODE_INFO: begin
        r.total_blocks  = act_count;
        r.size_of_block = act_size;
      end
      default: r.status = ST_UNAVAIL;
    endcase
    r.free_blocks   = n_free;
    r.waiting_count = n_wait;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reg_base  = '0;
      reg_size  = SIZE_W'(64);
      reg_count = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) idx_ring[i] = '0;
      rd_ptr    = '0;
      wr_ptr    = '0;
      n_free    = '0;
      n_wait    = '0;
      act_base  = '0;
      act_size  = SIZE_W'(64);
      act_count = '0;
      expected_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RES_W-1:0]);
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with no request outstanding, expected none actual status %0d",
                   $time, got.status);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("granted_index", 32'(want.granted_index), 32'(got.granted_index));
          check_field("granted_address", want.granted_address, got.granted_address);
          check_field("free_blocks", 32'(want.free_blocks), 32'(got.free_blocks));
          check_field("waiting_count", 32'(want.waiting_count), 32'(got.waiting_count));
          check_field("removed_waiters", 32'(want.removed_waiters),
                      32'(got.removed_waiters));
          check_field("total_blocks", 32'(want.total_blocks), 32'(got.total_blocks));
          check_field("size_of_block", 32'(want.size_of_block), 32'(got.size_of_block));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ADDRESS: reg_base  = cfg_data;
          REG_BLOCK_SIZE:   reg_size  = cfg_data[SIZE_W-1:0];
          REG_BLOCK_COUNT:  reg_count = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_replies.push_back(pool_step(s_tdata[2:0], s_tdata[10:3]));
    end
    pending <= expected_replies.size();
  end

endmodule

// ===== test/fixed_block_pool_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test
// Drives the block pool allocator with a directed set of corner requests,
// a waiter saturation run and randomized request mixes under several pool
// settings, with random gaps on both stream sides. Replies are checked by
// fbpa_result_checker.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int         PHASES       = 12;
  localparam int         PHASE_ITEMS  = 114;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [ADDR_W-1:0]  cfg_data  = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata   = '0;
  logic               m_tvalid;
  logic               m_tready  = 1'b1;
  logic [TDATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int n_items    = 0;
  int n_settings = 0;
  int stall_left = 0;
  bit quiet      = 1'b0;

  fixed_block_pool_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  fbpa_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(16, 48);
  endfunction

  // receiver backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      stall_left <= pick_gap() - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_req(input logic [2:0] mode, input logic [IDX_W-1:0] idx);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, idx, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic write_pool_cfg(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                                input logic [CNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE_ADDRESS;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data  <= {16'd0, size};
    @(posedge clk);
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data  <= {23'd0, count};
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_idle(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    int                count;
    int                alloc_pct;
    int                r;
    logic [2:0]        mode;
    logic [IDX_W-1:0]  idx;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pool: empty, size 64
    send_req(MODE_INFO, 8'h00);
    send_req(MODE_ALLOC, 8'hFF);
    send_req(MODE_ALLOC_WAIT, 8'h00);
    send_req(MODE_ALLOC_WAIT, 8'hFF);
    send_req(MODE_FREE, 8'hFF);
    send_req(MODE_DESTROY, 8'h00);
    send_req(MODE_DESTROY, 8'h00);
    send_req(MODE_SPARE_A, 8'h5A);
    send_req(MODE_SPARE_B, 8'hA5);
    send_req(MODE_FREE, 8'h00);
    send_req(MODE_ALLOC, 8'h00);
    wait_idle(8);

    // size below minimum, init must be rejected
    write_pool_cfg(32'h0, 16'd7, 9'd4);
    send_req(MODE_INIT, 8'h00);
    send_req(MODE_INFO, 8'h00);
    wait_idle(8);

    // oversized count clipped, address wrap, full ring
    write_pool_cfg(32'hFFFF_FFF0, 16'hFFFF, 9'h1FF);
    send_req(MODE_INIT, 8'h00);
    send_req(MODE_ALLOC, 8'h00);
    send_req(MODE_ALLOC, 8'h00);
    send_req(MODE_FREE, 8'hAA);
    send_req(MODE_FREE, 8'h55);
    send_req(MODE_FREE, 8'h00);
    send_req(MODE_DESTROY, 8'h00);
    send_req(MODE_INFO, 8'h00);
    wait_idle(8);

    // single block, foreign index freed and reissued
    write_pool_cfg(32'h0, SIZE_MIN, 9'd1);
    send_req(MODE_INIT, 8'h00);
    send_req(MODE_ALLOC, 8'h00);
    send_req(MODE_ALLOC, 8'h00);
    send_req(MODE_FREE, 8'd200);
    send_req(MODE_ALLOC, 8'h00);
    wait_idle(8);

    // waiter saturation
    write_pool_cfg($urandom, SIZE_MIN, 9'd0);
    send_req(MODE_INIT, 8'h00);
    repeat (MAX_WAITERS + 3) send_req(MODE_ALLOC_WAIT, IDX_W'($urandom_range(0, 255)));
    send_req(MODE_ALLOC, 8'h00);
    repeat (20) send_req(MODE_FREE, IDX_W'($urandom_range(0, 255)));
    send_req(MODE_DESTROY, 8'h00);
    send_req(MODE_INFO, 8'h00);
    wait_idle(8);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          base = '0;
          size = SIZE_MIN;
          count = 0;
        end
        1: begin
          base = '1;
          size = 16'hFFFF;
          count = MAX_BLOCKS;
        end
        2: begin
          base = $urandom;
          size = 16'd1;
          count = $urandom_range(1, 16);
        end
        default: begin
          r = $urandom_range(0, 99);
          base = (r < 15) ? 32'h0 : (r < 30) ? 32'hFFFF_FFFF : 32'($urandom);
          r = $urandom_range(0, 99);
          if (r < 10) size = SIZE_W'($urandom_range(1, 7));
          else if (r < 20) size = 16'hFFFF;
          else if (r < 30) size = SIZE_MIN;
          else size = SIZE_W'($urandom_range(9, 4096));
          r = $urandom_range(0, 99);
          if (r < 15) count = 0;
          else if (r < 30) count = MAX_BLOCKS;
          else if (r < 35) count = $urandom_range(257, 511);
          else if (r < 75) count = $urandom_range(1, 16);
          else count = $urandom_range(17, 255);
        end
      endcase
      case ($urandom_range(0, 2))
        0: alloc_pct = 20;
        1: alloc_pct = 45;
        default: alloc_pct = 70;
      endcase
      quiet <= ($urandom_range(0, 3) == 0);
      write_pool_cfg(base, size, count[CNT_W-1:0]);
      send_req(MODE_INIT, IDX_W'($urandom_range(0, 255)));
      if (count > MAX_BLOCKS) count = MAX_BLOCKS;
      repeat (PHASE_ITEMS) begin
        r   = $urandom_range(0, 99);
        idx = IDX_W'($urandom_range(0, 255));
        if (r < alloc_pct) begin
          mode = $urandom_range(0, 1) ? MODE_ALLOC : MODE_ALLOC_WAIT;
        end else if (r < 88) begin
          mode = MODE_FREE;
          if (count > 0 && $urandom_range(0, 9) < 7) idx = IDX_W'($urandom_range(0, count - 1));
        end else if (r < 92) begin
          mode = MODE_DESTROY;
        end else if (r < 96) begin
          mode = MODE_INFO;
        end else if (r < 98) begin
          mode = MODE_INIT;
        end else begin
          mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        end
        send_req(mode, idx);
      end
      wait_idle(8);
    end

    quiet <= 1'b0;
    wait_idle(300);
    $display("Ran %0d pool requests across %0d pool settings", n_items, n_settings);
    $display("including rejected init, clipped count, waiter saturation and full ring");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dp.sv
hw/rtl/fixed_block_pool_allocator.sv
test/fbpa_result_checker.sv
test/fixed_block_pool_allocator_test.sv
